/* src/four_point_hull_radon_partition_assert.svh */
`ifndef FOUR_POINT_HULL_RADON_PARTITION_ASSERT_SVH
`define FOUR_POINT_HULL_RADON_PARTITION_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define HRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/hrp_pkg.sv */
package hrp_pkg;

	localparam int unsigned COORD_BITS_DEF = 16;
	localparam int unsigned NUM_PTS = 4;

	typedef enum logic [1:0] {
		KIND_SEGMENT  = 2'd0,
		KIND_TRIANGLE = 2'd1,
		KIND_QUAD     = 2'd2
	} hull_kind_t;

	typedef logic [1:0] pt_idx_t;
	typedef logic [NUM_PTS-1:0] pt_mask_t;

	localparam pt_mask_t SEG_DEFAULT_MASK = 4'b0011;

	typedef struct packed {
		logic pos;
		logic neg;
	} ori_t;

	typedef ori_t [NUM_PTS-1:0] ori_vec_t;

	typedef logic [NUM_PTS-1:0][NUM_PTS-1:0] pt_rel_t;

	typedef struct packed {
		pt_rel_t eq;
		pt_rel_t ltx;
		pt_rel_t lty;
	} rel_t;

	typedef struct packed {
		logic s1;
		logic s2;
	} stage_en_t;

endpackage

/* src/hrp_pts_if.sv */
interface hrp_pts_if #(
	parameter int unsigned COORD_BITS = hrp_pkg::COORD_BITS_DEF
);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] x0;
	logic signed [COORD_BITS-1:0] y0;
	logic signed [COORD_BITS-1:0] x1;
	logic signed [COORD_BITS-1:0] y1;
	logic signed [COORD_BITS-1:0] x2;
	logic signed [COORD_BITS-1:0] y2;
	logic signed [COORD_BITS-1:0] x3;
	logic signed [COORD_BITS-1:0] y3;

	modport source (
		output valid, x0, y0, x1, y1, x2, y2, x3, y3,
		input ready
	);

	modport sink (
		input valid, x0, y0, x1, y1, x2, y2, x3, y3,
		output ready
	);
endinterface

/* src/hrp_res_if.sv */
interface hrp_res_if;
	import hrp_pkg::*;

	logic valid;
	logic ready;
	hull_kind_t hull_kind;
	pt_mask_t set_i_mask;
	pt_idx_t anchor_index;

	modport source (
		output valid, hull_kind, set_i_mask, anchor_index,
		input ready
	);

	modport sink (
		input valid, hull_kind, set_i_mask, anchor_index,
		output ready
	);
endinterface

/* src/hrp_lane.sv */
module hrp_lane #(
	parameter int unsigned COORD_BITS = hrp_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  hrp_pkg::stage_en_t            en,
	input  logic signed [COORD_BITS-1:0]  ax,
	input  logic signed [COORD_BITS-1:0]  ay,
	input  logic signed [COORD_BITS-1:0]  bx,
	input  logic signed [COORD_BITS-1:0]  by,
	input  logic signed [COORD_BITS-1:0]  cx,
	input  logic signed [COORD_BITS-1:0]  cy,
	output hrp_pkg::ori_t                 ori_s2
);
	import hrp_pkg::*;

	logic signed [COORD_BITS:0]     dxb;
	logic signed [COORD_BITS:0]     dyb;
	logic signed [COORD_BITS:0]     dxc;
	logic signed [COORD_BITS:0]     dyc;
	logic signed [2*COORD_BITS+1:0] prod_l_s1;
	logic signed [2*COORD_BITS+1:0] prod_r_s1;

	assign dxb = $signed({bx[COORD_BITS-1], bx}) - $signed({ax[COORD_BITS-1], ax});
	assign dyb = $signed({by[COORD_BITS-1], by}) - $signed({ay[COORD_BITS-1], ay});
	assign dxc = $signed({cx[COORD_BITS-1], cx}) - $signed({ax[COORD_BITS-1], ax});
	assign dyc = $signed({cy[COORD_BITS-1], cy}) - $signed({ay[COORD_BITS-1], ay});

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_l_s1 <= dxb * dyc;
			prod_r_s1 <= dyb * dxc;
		end
		if (en.s2) begin
			ori_s2.pos <= prod_l_s1 > prod_r_s1;
			ori_s2.neg <= prod_l_s1 < prod_r_s1;
		end
	end
endmodule

/* src/hrp_merge.sv */
module hrp_merge (
	input  hrp_pkg::ori_vec_t  ori,
	input  hrp_pkg::rel_t      rel,
	output hrp_pkg::hull_kind_t kind,
	output hrp_pkg::pt_mask_t  set_i_mask,
	output hrp_pkg::pt_idx_t   anchor
);
	import hrp_pkg::*;

	// Each lane holds the orientation of the sorted triple that leaves out one point.
	// Any other ordering of that triple follows from the parity of the permutation.
	function automatic ori_t ori3(ori_vec_t o, pt_idx_t a, pt_idx_t b, pt_idx_t c);
		ori_t r;
		logic flip;
		r = o[a ^ b ^ c];
		flip = (a > b) ^ (a > c) ^ (b > c);
		if (flip) begin
			r = '{pos: r.neg, neg: r.pos};
		end
		return r;
	endfunction

	function automatic logic between(pt_rel_t lt, pt_idx_t p, pt_idx_t a, pt_idx_t b);
		return !(lt[p][a] && lt[p][b]) && !(lt[a][p] && lt[b][p]);
	endfunction

	function automatic logic is_zero(ori_t o);
		return !o.pos && !o.neg;
	endfunction

	function automatic logic same_side(ori_t o, ori_t t);
		return !(o.pos && t.neg) && !(o.neg && t.pos);
	endfunction

	function automatic logic on_seg(ori_vec_t o, rel_t r, pt_idx_t p, pt_idx_t a,
			pt_idx_t b);
		return is_zero(ori3(o, a, b, p)) && between(r.ltx, p, a, b) &&
			between(r.lty, p, a, b);
	endfunction

	function automatic logic in_hull(ori_vec_t o, rel_t r, pt_idx_t p, pt_idx_t s0,
			pt_idx_t s1, pt_idx_t s2, logic [1:0] n);
		ori_t t;
		logic res;
		t = ori3(o, s0, s1, s2);
		unique case (n)
			2'd0: res = 1'b0;
			2'd1: res = r.eq[p][s0];
			2'd2: res = on_seg(o, r, p, s0, s1);
			default: begin
				if (is_zero(t)) begin
					res = on_seg(o, r, p, s0, s1) || on_seg(o, r, p, s0, s2) ||
						on_seg(o, r, p, s1, s2);
				end else begin
					res = same_side(ori3(o, s0, s1, p), t) &&
						same_side(ori3(o, s1, s2, p), t) &&
						same_side(ori3(o, s2, s0, p), t);
				end
			end
		endcase
		return res;
	endfunction

	always_comb begin
		pt_mask_t   uniq;
		pt_mask_t   vm;
		pt_mask_t   imask;
		pt_idx_t    s [NUM_PTS];
		logic [1:0] n;
		logic [2:0] h;
		pt_idx_t    anc;
		pt_idx_t    b0;
		pt_idx_t    b1;
		logic       bsel;
		logic       found;
		ori_t       o0;
		ori_t       o1;

		anc = '0;
		for (int i = 1; i < NUM_PTS; i++) begin
			if (rel.lty[i][anc] || (!rel.lty[anc][i] && rel.ltx[i][anc])) begin
				anc = pt_idx_t'(i);
			end
		end

		for (int i = 0; i < NUM_PTS; i++) begin
			uniq[i] = 1'b1;
			for (int j = 0; j < i; j++) begin
				if (rel.eq[j][i]) begin
					uniq[i] = 1'b0;
				end
			end
		end

		for (int i = 0; i < NUM_PTS; i++) begin
			n = '0;
			for (int k = 0; k < NUM_PTS; k++) begin
				s[k] = '0;
			end
			for (int j = 0; j < NUM_PTS; j++) begin
				if (j != i && uniq[j]) begin
					s[n] = pt_idx_t'(j);
					n = n + 2'd1;
				end
			end
			vm[i] = uniq[i] && ((n == 2'd0) ||
				!in_hull(ori, rel, pt_idx_t'(i), s[0], s[1], s[2], n));
		end
		h = 3'($countones(vm));

		found = 1'b0;
		imask = '0;
		imask[anc] = 1'b1;
		for (int i = 0; i < NUM_PTS; i++) begin
			b0 = '0;
			b1 = '0;
			bsel = 1'b0;
			for (int j = 0; j < NUM_PTS; j++) begin
				if (j != anc && j != i) begin
					if (!bsel) begin
						b0 = pt_idx_t'(j);
					end else begin
						b1 = pt_idx_t'(j);
					end
					bsel = 1'b1;
				end
			end
			o0 = ori3(ori, anc, pt_idx_t'(i), b0);
			o1 = ori3(ori, anc, pt_idx_t'(i), b1);
			if (!found && i != anc && ((o0.pos && o1.neg) || (o0.neg && o1.pos))) begin
				imask[i] = 1'b1;
				found = 1'b1;
			end
		end

		priority if (h == 3'd4) begin
			kind = KIND_QUAD;
			set_i_mask = imask;
		end else if (h == 3'd3) begin
			kind = KIND_TRIANGLE;
			set_i_mask = vm;
		end else begin
			kind = KIND_SEGMENT;
			set_i_mask = (h == 3'd2) ? vm : SEG_DEFAULT_MASK;
		end
		anchor = anc;
	end
endmodule

/* src/four_point_hull_radon_partition.sv */
// Channel  Direction  Word contents
// points   in         x0 y0 x1 y1 x2 y2 x3 y3, COORD_BITS each, two's complement
// result   out        hull_kind, set_i_mask, anchor_index
//
// One word is taken per cycle while the result is not stalled; each word gives one result.
// The four orientation lanes register the products in stage s1 and the compare in stage s2.
// The merge stage classifies the hull combinationally and fills the result register.
// A stalled result holds the pipe; ready upstream is low only while every stage is full.
// Reset clears the stage valid bits alone; no state carries from word to word.
`include "four_point_hull_radon_partition_assert.svh"

module four_point_hull_radon_partition #(
	parameter int unsigned COORD_BITS = hrp_pkg::COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hrp_pts_if.sink    points,
	hrp_res_if.source  result
);
	import hrp_pkg::*;

	logic signed [COORD_BITS-1:0] px [NUM_PTS];
	logic signed [COORD_BITS-1:0] py [NUM_PTS];
	stage_en_t  en;
	logic       adv_out;
	logic       vld_s1;
	logic       vld_s2;
	logic       out_vld_q;
	rel_t       rel_c;
	rel_t       rel_s1;
	rel_t       rel_s2;
	ori_vec_t   ori_s2;
	hull_kind_t kind_c;
	pt_mask_t   mask_c;
	pt_idx_t    anchor_c;
	hull_kind_t kind_q;
	pt_mask_t   mask_q;
	pt_idx_t    anchor_q;

	assign px[0] = points.x0;
	assign py[0] = points.y0;
	assign px[1] = points.x1;
	assign py[1] = points.y1;
	assign px[2] = points.x2;
	assign py[2] = points.y2;
	assign px[3] = points.x3;
	assign py[3] = points.y3;

	assign adv_out = !out_vld_q || result.ready;
	assign en.s2 = !vld_s2 || adv_out;
	assign en.s1 = !vld_s1 || en.s2;
	assign points.ready = en.s1;

	always_comb begin
		for (int j = 0; j < NUM_PTS; j++) begin
			for (int k = 0; k < NUM_PTS; k++) begin
				rel_c.eq[j][k] = (px[j] == px[k]) && (py[j] == py[k]);
				rel_c.ltx[j][k] = px[j] < px[k];
				rel_c.lty[j][k] = py[j] < py[k];
			end
		end
	end

	for (genvar d = 0; d < NUM_PTS; d++) begin : g_lane
		localparam int unsigned IA = (d == 0) ? 1 : 0;
		localparam int unsigned IB = (d <= 1) ? 2 : 1;
		localparam int unsigned IC = (d <= 2) ? 3 : 2;

		hrp_lane #(
			.COORD_BITS(COORD_BITS)
		) u_lane (
			.clk    (clk),
			.en     (en),
			.ax     (px[IA]),
			.ay     (py[IA]),
			.bx     (px[IB]),
			.by     (py[IB]),
			.cx     (px[IC]),
			.cy     (py[IC]),
			.ori_s2 (ori_s2[d])
		);
	end

	hrp_merge u_merge (
		.ori        (ori_s2),
		.rel        (rel_s2),
		.kind       (kind_c),
		.set_i_mask (mask_c),
		.anchor     (anchor_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en.s1) begin
				vld_s1 <= points.valid;
			end
			if (en.s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv_out) begin
				out_vld_q <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			rel_s1 <= rel_c;
		end
		if (en.s2) begin
			rel_s2 <= rel_s1;
		end
		if (adv_out) begin
			kind_q <= kind_c;
			mask_q <= mask_c;
			anchor_q <= anchor_c;
		end
	end

	assign result.valid = out_vld_q;
	assign result.hull_kind = kind_q;
	assign result.set_i_mask = mask_q;
	assign result.anchor_index = anchor_q;

	`HRP_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, points.valid && points.ready, vld_s1, "accepted word did not reach the first stage")
	`HRP_ASSERT_NOW(a_quad_pair, clk, arst_n, result.valid && result.hull_kind == KIND_QUAD, $countones(result.set_i_mask) == 2 && result.set_i_mask[result.anchor_index], "quadrilateral set I is not the anchor and one opposite vertex")
	`HRP_ASSERT_NOW(a_tri_three, clk, arst_n, result.valid && result.hull_kind == KIND_TRIANGLE, $countones(result.set_i_mask) == 3, "triangle set I does not hold three vertices")
	`HRP_ASSERT_NOW(a_seg_two, clk, arst_n, result.valid && result.hull_kind == KIND_SEGMENT, $countones(result.set_i_mask) == 2, "segment set I does not hold two points")
endmodule

/* sim/four_point_hull_radon_partition_tb.sv */
`timescale 1ns / 100ps

module four_point_hull_radon_partition_tb;
	import hrp_pkg::*;

	localparam int unsigned CB = COORD_BITS_DEF;
	localparam int RANDOM_WORDS = 900;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int REPORT_LIMIT = 10;

	typedef logic signed [CB-1:0] coord_t;

	localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};
	localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};

	typedef struct packed {
		coord_t [3:0] x;
		coord_t [3:0] y;
	} quad_t;

	typedef struct packed {
		hull_kind_t kind;
		pt_mask_t   mask;
		pt_idx_t    anchor;
	} partition_t;

	typedef struct {
		quad_t      q;
		bit         typed;
		partition_t want;
	} quad_row_t;

	logic clk;
	logic arst_n;

	hrp_pts_if #(.COORD_BITS(CB)) points();
	hrp_res_if result();

	four_point_hull_radon_partition #(.COORD_BITS(CB)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(points),
		.result(result)
	);

	partition_t expected_partitions[$];
	int mismatches = 0;
	int cycles = 0;
	int words_sent = 0;
	int kinds_seen[3] = '{0, 0, 0};
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	bit typed_now = 1'b0;
	partition_t typed_want = '0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int cross_sign(input longint px[4], input longint py[4],
			input int a, input int b, input int c);
		longint l;
		longint r;
		l = (px[b] - px[a]) * (py[c] - py[a]);
		r = (py[b] - py[a]) * (px[c] - px[a]);
		if (l > r) return 1;
		if (l < r) return -1;
		return 0;
	endfunction

	function automatic bit on_segment(input longint px[4], input longint py[4],
			input int p, input int a, input int b);
		longint lx, hx, ly, hy;
		lx = (px[a] < px[b]) ? px[a] : px[b];
		hx = (px[a] < px[b]) ? px[b] : px[a];
		ly = (py[a] < py[b]) ? py[a] : py[b];
		hy = (py[a] < py[b]) ? py[b] : py[a];
		if (cross_sign(px, py, a, b, p) != 0) return 1'b0;
		return px[p] >= lx && px[p] <= hx && py[p] >= ly && py[p] <= hy;
	endfunction

	// Closed hull test of point p against up to three other distinct points.
	function automatic bit in_closed_hull(input longint px[4], input longint py[4],
			input int p, input int s[3], input int n);
		int t, o0, o1, o2;
		case (n)
			1: return px[p] == px[s[0]] && py[p] == py[s[0]];
			2: return on_segment(px, py, p, s[0], s[1]);
			3: begin
				t = cross_sign(px, py, s[0], s[1], s[2]);
				if (t == 0)
					return on_segment(px, py, p, s[0], s[1]) ||
						on_segment(px, py, p, s[0], s[2]) ||
						on_segment(px, py, p, s[1], s[2]);
				o0 = cross_sign(px, py, s[0], s[1], p) * t;
				o1 = cross_sign(px, py, s[1], s[2], p) * t;
				o2 = cross_sign(px, py, s[2], s[0], p) * t;
				return o0 >= 0 && o1 >= 0 && o2 >= 0;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic partition_t predict_partition(input quad_t q);
		longint px[4], py[4];
		bit distinct[4];
		int s[3];
		int b[2];
		int n, nb, h, anchor;
		pt_mask_t vmask, imask;
		partition_t r;
		for (int i = 0; i < 4; i++) begin
			px[i] = longint'($signed(q.x[i]));
			py[i] = longint'($signed(q.y[i]));
		end
		anchor = 0;
		for (int i = 1; i < 4; i++)
			if (py[i] < py[anchor] || (py[i] == py[anchor] && px[i] < px[anchor]))
				anchor = i;
		for (int i = 0; i < 4; i++) begin
			distinct[i] = 1'b1;
			for (int j = 0; j < i; j++)
				if (px[j] == px[i] && py[j] == py[i])
					distinct[i] = 1'b0;
		end
		vmask = '0;
		h = 0;
		for (int i = 0; i < 4; i++) begin
			if (!distinct[i]) continue;
			n = 0;
			s = '{0, 0, 0};
			for (int j = 0; j < 4; j++)
				if (j != i && distinct[j]) begin
					s[n] = j;
					n++;
				end
			if (n == 0 || !in_closed_hull(px, py, i, s, n)) begin
				vmask[i] = 1'b1;
				h++;
			end
		end
		if (h == 4) begin
			r.kind = KIND_QUAD;
			imask = '0;
			imask[anchor] = 1'b1;
			for (int i = 0; i < 4; i++) begin
				if (i == anchor) continue;
				nb = 0;
				for (int j = 0; j < 4; j++)
					if (j != anchor && j != i) begin
						b[nb] = j;
						nb++;
					end
				if (cross_sign(px, py, anchor, i, b[0]) *
						cross_sign(px, py, anchor, i, b[1]) < 0) begin
					imask[i] = 1'b1;
					break;
				end
			end
		end else if (h == 3) begin
			r.kind = KIND_TRIANGLE;
			imask = vmask;
		end else begin
			r.kind = KIND_SEGMENT;
			imask = (h == 2) ? vmask : SEG_DEFAULT_MASK;
		end
		r.mask = imask;
		r.anchor = pt_idx_t'(anchor);
		return r;
	endfunction

	function automatic quad_row_t quad_row(input int x0, input int y0, input int x1,
			input int y1, input int x2, input int y2, input int x3, input int y3,
			input bit typed = 1'b0, input hull_kind_t kind = KIND_SEGMENT,
			input pt_mask_t mask = '0, input pt_idx_t anchor = '0);
		quad_row_t r;
		r.q.x = {coord_t'(x3), coord_t'(x2), coord_t'(x1), coord_t'(x0)};
		r.q.y = {coord_t'(y3), coord_t'(y2), coord_t'(y1), coord_t'(y0)};
		r.typed = typed;
		r.want.kind = kind;
		r.want.mask = mask;
		r.want.anchor = anchor;
		return r;
	endfunction

	function automatic coord_t extreme_coord();
		case ($urandom_range(0, 6))
			0: return CMIN;
			1: return coord_t'(CMIN + coord_t'(1));
			2: return coord_t'(-1);
			3: return coord_t'(0);
			4: return coord_t'(1);
			5: return coord_t'(CMAX - coord_t'(1));
			default: return CMAX;
		endcase
	endfunction

	function automatic quad_t random_quad();
		quad_t q;
		coord_t bx[3], by[3];
		coord_t tmp;
		int ax, ay, dx, dy, t, k, pick, a, b;
		q = '0;
		case ($urandom_range(0, 9))
			0, 1, 2: q = {$urandom, $urandom, $urandom, $urandom};
			3, 4: begin
				for (int i = 0; i < 4; i++) begin
					q.x[i] = coord_t'(int'($urandom_range(0, 6)) - 3);
					q.y[i] = coord_t'(int'($urandom_range(0, 6)) - 3);
				end
			end
			5: begin
				if ($urandom_range(0, 1)) begin
					ax = int'($urandom_range(0, 2000)) - 1000;
					ay = int'($urandom_range(0, 2000)) - 1000;
					dx = int'($urandom_range(0, 100)) - 50;
					dy = int'($urandom_range(0, 100)) - 50;
					for (int i = 0; i < 4; i++) begin
						t = int'($urandom_range(0, 10)) - 5;
						q.x[i] = coord_t'(ax + t * dx);
						q.y[i] = coord_t'(ay + t * dy);
					end
				end else begin
					tmp = coord_t'($urandom);
					pick = $urandom_range(0, 1);
					for (int i = 0; i < 4; i++) begin
						q.x[i] = pick ? tmp : coord_t'($urandom);
						q.y[i] = pick ? coord_t'($urandom) : tmp;
					end
				end
			end
			6: begin
				k = $urandom_range(1, 3);
				pick = $urandom_range(0, 1);
				for (int j = 0; j < 3; j++) begin
					bx[j] = pick ? coord_t'($urandom) : coord_t'(int'($urandom_range(0, 4)) - 2);
					by[j] = pick ? coord_t'($urandom) : coord_t'(int'($urandom_range(0, 4)) - 2);
				end
				for (int i = 0; i < 4; i++) begin
					t = $urandom_range(0, k - 1);
					q.x[i] = bx[t];
					q.y[i] = by[t];
				end
			end
			7: begin
				for (int j = 0; j < 3; j++) begin
					bx[j] = coord_t'($urandom & 32'hFFFF_FFFE);
					by[j] = coord_t'($urandom & 32'hFFFF_FFFE);
					q.x[j] = bx[j];
					q.y[j] = by[j];
				end
				if ($urandom_range(0, 1)) begin
					a = $urandom_range(0, 2);
					b = (a + 1 + $urandom_range(0, 1)) % 3;
					q.x[3] = coord_t'((int'(bx[a]) + int'(bx[b])) / 2);
					q.y[3] = coord_t'((int'(by[a]) + int'(by[b])) / 2);
				end else begin
					q.x[3] = coord_t'((int'(bx[0]) + int'(bx[1]) + int'(bx[2])) / 3);
					q.y[3] = coord_t'((int'(by[0]) + int'(by[1]) + int'(by[2])) / 3);
				end
				pick = $urandom_range(0, 3);
				tmp = q.x[3];
				q.x[3] = q.x[pick];
				q.x[pick] = tmp;
				tmp = q.y[3];
				q.y[3] = q.y[pick];
				q.y[pick] = tmp;
			end
			default: begin
				for (int i = 0; i < 4; i++) begin
					q.x[i] = extreme_coord();
					q.y[i] = extreme_coord();
				end
			end
		endcase
		return q;
	endfunction

	task automatic send_word(input quad_t q, input bit typed, input partition_t want);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			points.valid <= 1'b0;
			@(negedge clk);
		end
		points.valid <= 1'b1;
		{points.x3, points.x2, points.x1, points.x0} <= q.x;
		{points.y3, points.y2, points.y1, points.y0} <= q.y;
		typed_now <= typed;
		typed_want <= want;
		do @(posedge clk); while (!(points.valid && points.ready));
		words_sent++;
		@(negedge clk);
	endtask

	always @(negedge clk)
		result.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

	always @(posedge clk) begin
		quad_t seen;
		partition_t want;
		if (arst_n) begin
			if (points.valid && points.ready) begin
				seen.x = {points.x3, points.x2, points.x1, points.x0};
				seen.y = {points.y3, points.y2, points.y1, points.y0};
				want = typed_now ? typed_want : predict_partition(seen);
				kinds_seen[want.kind]++;
				expected_partitions.push_back(want);
			end
			if (result.valid && result.ready) begin
				if (expected_partitions.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: unexpected result kind %0d mask %b anchor %0d",
							$realtime, result.hull_kind, result.set_i_mask,
							result.anchor_index);
					mismatches++;
				end else begin
					want = expected_partitions.pop_front();
					if (result.hull_kind !== want.kind || result.set_i_mask !== want.mask ||
							result.anchor_index !== want.anchor) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: expected kind %0d mask %b anchor %0d, got kind %0d mask %b anchor %0d",
								$realtime, want.kind, want.mask, want.anchor,
								result.hull_kind, result.set_i_mask, result.anchor_index);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycles, expected_partitions.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		quad_row_t rows[$];
		arst_n = 1'b0;
		points.valid = 1'b0;
		{points.x0, points.y0, points.x1, points.y1} = '0;
		{points.x2, points.y2, points.x3, points.y3} = '0;

		// Coincident points, extreme squares and degenerate shapes.
		rows.push_back(quad_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, KIND_SEGMENT, SEG_DEFAULT_MASK, 0));
		rows.push_back(quad_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
			1'b1, KIND_SEGMENT, SEG_DEFAULT_MASK, 0));
		rows.push_back(quad_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
			1'b1, KIND_SEGMENT, SEG_DEFAULT_MASK, 0));
		rows.push_back(quad_row(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
			1'b1, KIND_QUAD, 4'b0101, 0));
		rows.push_back(quad_row(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767,
			1'b1, KIND_QUAD, 4'b1100, 2));
		rows.push_back(quad_row(0, 0, 100, 0, 0, 100, 10, 10, 1'b1, KIND_TRIANGLE, 4'b0111, 0));
		rows.push_back(quad_row(0, 0, 100, 0, 0, 100, 50, 0, 1'b1, KIND_TRIANGLE, 4'b0111, 0));
		rows.push_back(quad_row(32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768));
		rows.push_back(quad_row(0, 0, 3, 3, 1, 1, 2, 2));
		rows.push_back(quad_row(5, 5, 5, 5, 9, 9, 9, 9));
		rows.push_back(quad_row(1, 2, 1, 2, 1, 2, 7, -3));
		rows.push_back(quad_row(0, 0, 10, 0, 0, 10, 0, 0));
		rows.push_back(quad_row(5, -1, 2, -1, 3, 4, -7, 10));
		rows.push_back(quad_row(-32768, -32768, 32767, 32767, 0, 0, -1, -1));
		rows.push_back(quad_row(-32768, -32768, 32767, 32767, 32767, 32766, -32768, -32767));
		rows.push_back(quad_row(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846));
		rows.push_back(quad_row(10, 10, 0, 0, 100, 0, 0, 100));
		rows.push_back(quad_row(-1, -1, -1, -1, 4, 4, -1, -1));
		rows.push_back(quad_row(0, 5, 0, -5, 0, 0, 0, 5));
		rows.push_back(quad_row(3, 0, 1, 0, 2, 0, 0, 0));
		rows.push_back(quad_row(0, 0, 4, 0, 4, 4, 1, 3));
		rows.push_back(quad_row(-32768, 0, 32767, 0, 0, 32767, 0, -32768));
		rows.push_back(quad_row(32767, -32768, -32768, 32767, 0, -1, -1, 0));

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 82 : 0;
			snk_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 10 : 0;
			if (phase == 0)
				foreach (rows[k])
					send_word(rows[k].q, rows[k].typed, rows[k].want);
			repeat (RANDOM_WORDS / 3)
				send_word(random_quad(), 1'b0, '0);
		end
		points.valid <= 1'b0;

		wait (expected_partitions.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d point quads (%0d directed) under three idle patterns.",
			words_sent, rows.size());
		$display("Expected %0d segments, %0d triangles, %0d quadrilaterals; %0d mismatches.",
			kinds_seen[0], kinds_seen[1], kinds_seen[2], mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* four_point_hull_radon_partition.f */
+incdir+src
src/hrp_pkg.sv
src/hrp_pts_if.sv
src/hrp_res_if.sv
src/hrp_lane.sv
src/hrp_merge.sv
src/four_point_hull_radon_partition.sv
sim/four_point_hull_radon_partition_tb.sv
